FILE: design/sjfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_pkg
// Shared types and codes for the shortest-job-first job queue: command and
// status codes, cell operation codes and the cell control struct.
// ----------------------------------------------------------------------------
package sjfq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int ID_W          = 16;
    localparam int RT_W          = 32;

    // Commands
    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_DEQ    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SORT   = 2'd3;

    // Result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Cell operations
    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_SHIFT  = 3'd2;
    localparam logic [2:0] OP_ROTATE = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic       phase;
    } sjfq_ctrl_t;

endpackage

FILE: design/sjfq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_cell
// One queue slot. Holds a job number and run time and, under a broadcast
// operation, loads from the enqueue bus, its right or left neighbor, or the
// head cell. Computes the compare-exchange decision when it is the lower
// cell of a sort pair.
// ----------------------------------------------------------------------------
module sjfq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = $clog2(sjfq_pkg::DEFAULT_DEPTH + 1)
) (
    input  logic                       clk,
    input  sjfq_pkg::sjfq_ctrl_t       ctrl,
    input  logic [CNT_W-1:0]           bound,
    input  logic [sjfq_pkg::ID_W-1:0]  enq_id,
    input  logic [sjfq_pkg::RT_W-1:0]  enq_rt,
    input  logic [sjfq_pkg::ID_W-1:0]  head_id,
    input  logic [sjfq_pkg::RT_W-1:0]  head_rt,
    input  logic [sjfq_pkg::ID_W-1:0]  left_id,
    input  logic [sjfq_pkg::RT_W-1:0]  left_rt,
    input  logic                       left_swap,
    input  logic [sjfq_pkg::ID_W-1:0]  right_id,
    input  logic [sjfq_pkg::RT_W-1:0]  right_rt,
    output logic [sjfq_pkg::ID_W-1:0]  id,
    output logic [sjfq_pkg::RT_W-1:0]  rt,
    output logic                       swap
);
    import sjfq_pkg::*;

    localparam logic [CNT_W-1:0] INDEX_POS  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] NEXT_POS   = CNT_W'(INDEX + 1);
    localparam logic             POS_PARITY = 1'(INDEX % 2);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic [RT_W-1:0] rt_reg;
    logic [RT_W-1:0] rt_next;
    logic            take_left;

    // Lower cell of a pair swaps on a strict compare, which keeps equal run
    // times in their order.
    assign swap = (ctrl.op == OP_SORT) && (POS_PARITY == ctrl.phase) &&
                  (NEXT_POS < bound) && (rt_reg > right_rt);
    assign take_left = (POS_PARITY != ctrl.phase) && left_swap;

    always_comb
    begin
        id_next = id_reg;
        rt_next = rt_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
            end
            OP_LOAD:
            begin
                if (INDEX_POS == bound)
                begin
                    id_next = enq_id;
                    rt_next = enq_rt;
                end
            end
            OP_SHIFT:
            begin
                id_next = right_id;
                rt_next = right_rt;
            end
            OP_ROTATE:
            begin
                // bound marks the tail: the head wraps around into it
                if (INDEX_POS == bound)
                begin
                    id_next = head_id;
                    rt_next = head_rt;
                end
                else if (INDEX_POS < bound)
                begin
                    id_next = right_id;
                    rt_next = right_rt;
                end
            end
            OP_SORT:
            begin
                if (swap)
                begin
                    id_next = right_id;
                    rt_next = right_rt;
                end
                else if (take_left)
                begin
                    id_next = left_id;
                    rt_next = left_rt;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        rt_reg <= rt_next;
    end

    assign id = id_reg;
    assign rt = rt_reg;

endmodule

FILE: design/sjf_job_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_job_queue_unit
// Bounded ready queue of jobs kept in order, with enqueue, dequeue, remove
// by job number and stable shortest-job-first sort, built as a row of cells.
// ----------------------------------------------------------------------------
// Sequencing: for enqueue, dequeue and any command on an empty queue (or
// enqueue on a full one) the result is registered at the accept edge.
// Remove by number, once accepted, scans: the queue rotates once through the
// head cell, one position per cycle, where the number is compared and the
// first match is dropped; a done state then posts the result once the output
// register is free. Sort runs count odd-even transposition phases across the
// cell row, then posts the result the same way. A new item is taken while a
// result waits, as long as the block is idle and the output register is free
// or being emptied in that cycle.
module sjf_job_queue_unit #(
    parameter int QUEUE_DEPTH = sjfq_pkg::DEFAULT_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [sjfq_pkg::ID_W-1:0]  job_id,
    input  logic [sjfq_pkg::RT_W-1:0]  job_runtime,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [sjfq_pkg::ID_W-1:0]  out_job_id,
    output logic [sjfq_pkg::RT_W-1:0]  out_runtime,
    output logic [4:0]                 entry_count
);
    import sjfq_pkg::*;

    localparam int               CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SORT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic             found_reg;
    logic             found_next;
    logic             phase_reg;
    logic             phase_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [ID_W-1:0]  key_reg;
    logic [ID_W-1:0]  key_next;
    logic [1:0]       res_status_reg;
    logic [1:0]       res_status_next;
    logic [ID_W-1:0]  res_id_reg;
    logic [ID_W-1:0]  res_id_next;
    logic [RT_W-1:0]  res_rt_reg;
    logic [RT_W-1:0]  res_rt_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [ID_W-1:0]  out_job_id_reg;
    logic [ID_W-1:0]  out_job_id_next;
    logic [RT_W-1:0]  out_runtime_reg;
    logic [RT_W-1:0]  out_runtime_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;

    logic             out_free;
    logic             accept;
    sjfq_ctrl_t       ctrl;
    logic [CNT_W-1:0] cell_bound;

    logic [ID_W-1:0]  cell_id   [QUEUE_DEPTH];
    logic [RT_W-1:0]  cell_rt   [QUEUE_DEPTH];
    logic             cell_swap [QUEUE_DEPTH];

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic [ID_W-1:0] left_id;
            logic [RT_W-1:0] left_rt;
            logic            left_swap;
            logic [ID_W-1:0] right_id;
            logic [RT_W-1:0] right_rt;

            if (g == 0)
            begin : g_first
                assign left_id   = cell_id[g];
                assign left_rt   = cell_rt[g];
                assign left_swap = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_id   = cell_id[g-1];
                assign left_rt   = cell_rt[g-1];
                assign left_swap = cell_swap[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_id = cell_id[g];
                assign right_rt = cell_rt[g];
            end
            else
            begin : g_inner_right
                assign right_id = cell_id[g+1];
                assign right_rt = cell_rt[g+1];
            end

            sjfq_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .bound     (cell_bound),
                .enq_id    (job_id),
                .enq_rt    (job_runtime),
                .head_id   (cell_id[0]),
                .head_rt   (cell_rt[0]),
                .left_id   (left_id),
                .left_rt   (left_rt),
                .left_swap (left_swap),
                .right_id  (right_id),
                .right_rt  (right_rt),
                .id        (cell_id[g]),
                .rt        (cell_rt[g]),
                .swap      (cell_swap[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        found_next       = found_reg;
        phase_next       = phase_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_rt_next      = res_rt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        out_job_id_next  = out_job_id_reg;
        out_runtime_next = out_runtime_reg;
        out_count_next   = out_count_reg;
        ctrl.op          = OP_HOLD;
        ctrl.phase       = phase_reg;
        cell_bound       = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // default result: nothing removed, count unchanged
                    out_valid_next   = 1'b1;
                    status_next      = STAT_OK;
                    out_job_id_next  = '0;
                    out_runtime_next = '0;
                    out_count_next   = count_reg;
                    unique case (command)
                        CMD_ENQ:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op        = OP_LOAD;
                                count_next     = count_reg + ONE_CNT;
                                out_count_next = count_reg + ONE_CNT;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.op          = OP_SHIFT;
                                count_next       = count_reg - ONE_CNT;
                                out_count_next   = count_reg - ONE_CNT;
                                out_job_id_next  = cell_id[0];
                                out_runtime_next = cell_rt[0];
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // hold the result until the scan finishes
                                out_valid_next = out_valid_reg && !out_ready;
                                state_next     = S_SCAN;
                                step_next      = count_reg;
                                key_next       = job_id;
                                found_next     = 1'b0;
                                res_id_next    = '0;
                                res_rt_next    = '0;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                state_next     = S_SORT;
                                step_next      = count_reg;
                                phase_next     = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // drop the first match at the head, recirculate everything else
                if (!found_reg && (cell_id[0] == key_reg))
                begin
                    ctrl.op     = OP_SHIFT;
                    found_next  = 1'b1;
                    res_id_next = cell_id[0];
                    res_rt_next = cell_rt[0];
                    count_next  = count_reg - ONE_CNT;
                end
                else
                begin
                    ctrl.op    = OP_ROTATE;
                    cell_bound = count_reg - ONE_CNT;
                end
                step_next = step_reg - ONE_CNT;
                if (step_reg == ONE_CNT)
                begin
                    state_next      = S_DONE;
                    res_status_next = found_next ? STAT_OK : STAT_NOTFOUND;
                end
            end
            S_SORT:
            begin
                ctrl.op    = OP_SORT;
                phase_next = !phase_reg;
                step_next  = step_reg - ONE_CNT;
                if (step_reg == ONE_CNT)
                begin
                    state_next      = S_DONE;
                    res_status_next = STAT_OK;
                    res_id_next     = '0;
                    res_rt_next     = '0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    out_job_id_next  = res_id_reg;
                    out_runtime_next = res_rt_reg;
                    out_count_next   = count_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        res_status_reg  <= res_status_next;
        res_id_reg      <= res_id_next;
        res_rt_reg      <= res_rt_next;
        status_reg      <= status_next;
        out_job_id_reg  <= out_job_id_next;
        out_runtime_reg <= out_runtime_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_job_id  = out_job_id_reg;
    assign out_runtime = out_runtime_reg;
    assign entry_count = 5'(out_count_reg);

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest-job-first job queue. A queue of
// commands feeds a bursty valid/ready driver; every accepted item updates a
// local queue model whose result is compared, field by field, with what the
// monitor takes from the output channel under a varying stall pattern.
// ----------------------------------------------------------------------------
module tb;

    import sjfq_pkg::*;

    localparam int QUEUE_DEPTH   = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS  = 875;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 400;

    typedef struct {
        logic [1:0]      command;
        logic [ID_W-1:0] id;
        logic [RT_W-1:0] runtime;
        bit              wait_drain;
    } job_cmd_t;

    typedef struct {
        logic [1:0]      status;
        logic [ID_W-1:0] id;
        logic [RT_W-1:0] runtime;
        logic [4:0]      count;
    } job_result_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    logic [1:0]      command     = CMD_ENQ;
    logic [ID_W-1:0] job_id      = '0;
    logic [RT_W-1:0] job_runtime = '0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    logic [1:0]      status;
    logic [ID_W-1:0] out_job_id;
    logic [RT_W-1:0] out_runtime;
    logic [4:0]      entry_count;

    sjf_job_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .job_id      (job_id),
        .job_runtime (job_runtime),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_job_id  (out_job_id),
        .out_runtime (out_runtime),
        .entry_count (entry_count)
    );

    always #5 clk = ~clk;

    job_cmd_t    pending_cmds[$];
    job_result_t expected_results[$];

    // Local copy of the job queue
    logic [ID_W-1:0] held_id[QUEUE_DEPTH];
    logic [RT_W-1:0] held_rt[QUEUE_DEPTH];
    int              held_n = 0;

    int mismatch_count = 0;
    int result_count   = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int sort_count     = 0;
    int cycle_count    = 0;

    function automatic void take_job(input int pos, output logic [ID_W-1:0] id,
                                     output logic [RT_W-1:0] runtime);
        id      = held_id[pos];
        runtime = held_rt[pos];
        for (int i = pos; i + 1 < held_n; i++)
        begin
            held_id[i] = held_id[i + 1];
            held_rt[i] = held_rt[i + 1];
        end
        held_n--;
    endfunction

    function automatic job_result_t apply_job_command(job_cmd_t c);
        job_result_t     r;
        int              pos;
        int              k;
        logic [ID_W-1:0] tid;
        logic [RT_W-1:0] trt;
        r.status  = STAT_OK;
        r.id      = '0;
        r.runtime = '0;
        case (c.command)
            CMD_ENQ:
            begin
                if (held_n >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    held_id[held_n] = c.id;
                    held_rt[held_n] = c.runtime;
                    held_n++;
                end
            end
            CMD_DEQ:
            begin
                if (held_n == 0)
                    r.status = STAT_EMPTY;
                else
                    take_job(0, r.id, r.runtime);
            end
            CMD_REMOVE:
            begin
                if (held_n == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    pos = -1;
                    for (int i = 0; i < held_n; i++)
                    begin
                        if (held_id[i] == c.id)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0)
                        r.status = STAT_NOTFOUND;
                    else
                        take_job(pos, r.id, r.runtime);
                end
            end
            default:
            begin
                if (held_n == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // stable insertion sort: strict compare keeps ties in order
                    for (int i = 1; i < held_n; i++)
                    begin
                        tid = held_id[i];
                        trt = held_rt[i];
                        k = i;
                        while (k > 0 && held_rt[k - 1] > trt)
                        begin
                            held_id[k] = held_id[k - 1];
                            held_rt[k] = held_rt[k - 1];
                            k--;
                        end
                        held_id[k] = tid;
                        held_rt[k] = trt;
                    end
                end
            end
        endcase
        r.count = 5'(held_n);
        return r;
    endfunction

    task automatic add_cmd(input logic [1:0] c, input logic [ID_W-1:0] id,
                           input logic [RT_W-1:0] runtime, input bit drain);
        job_cmd_t item;
        item.command    = c;
        item.id         = id;
        item.runtime    = runtime;
        item.wait_drain = drain;
        pending_cmds.push_back(item);
    endtask

    // Driver: bursts of items separated by idle gaps
    int burst_left = 1;
    int idle_left  = 0;

    always @(posedge clk)
    begin
        job_cmd_t taken;
        job_cmd_t next;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.command    = command;
                taken.id         = job_id;
                taken.runtime    = job_runtime;
                taken.wait_drain = 1'b0;
                if (command == CMD_SORT)
                    sort_count++;
                expected_results.push_back(apply_job_command(taken));
            end
            if (!in_valid || in_ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].wait_drain && expected_results.size() != 0))
                begin
                    next = pending_cmds.pop_front();
                    command     <= next.command;
                    job_id      <= next.id;
                    job_runtime <= next.runtime;
                    in_valid    <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        idle_left  = $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall pattern plus one long hold-off
    int  stall_mode     = 0;
    int  mode_left      = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (!long_hold_done && result_count >= 300)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 80);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        job_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            status_seen[status]++;
            if (expected_results.size() == 0)
            begin
                $error("tb: result with nothing expected (status %0d, id %0h)",
                       status, out_job_id);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (out_job_id !== want.id)
                begin
                    $error("out_job_id: expected %0h, got %0h", want.id, out_job_id);
                    mismatch_count++;
                end
                if (out_runtime !== want.runtime)
                begin
                    $error("out_runtime: expected %0h, got %0h", want.runtime, out_runtime);
                    mismatch_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [1:0] pick_command(int mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            0:       return roll < 70 ? CMD_ENQ : roll < 80 ? CMD_DEQ :
                            roll < 90 ? CMD_REMOVE : CMD_SORT;
            1:       return roll < 15 ? CMD_ENQ : roll < 55 ? CMD_DEQ :
                            roll < 90 ? CMD_REMOVE : CMD_SORT;
            2:       return roll < 50 ? CMD_ENQ : roll < 60 ? CMD_DEQ :
                            roll < 70 ? CMD_REMOVE : CMD_SORT;
            default: return 2'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 9);
        // small pool so removes find matches and duplicates
        if (roll < 8)
            return ID_W'($urandom_range(0, 7));
        else if (roll == 8)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return ID_W'($urandom);
    endfunction

    function automatic logic [RT_W-1:0] pick_runtime();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return RT_W'($urandom_range(0, 5));
        else if (roll == 4)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return RT_W'($urandom);
    endfunction

    initial
    begin
        int made;
        int seg_len;
        int mix;
        bit drain;

        // empty-queue cases
        add_cmd(CMD_DEQ, 16'h0, 32'h0, 1'b0);
        add_cmd(CMD_REMOVE, 16'h5, 32'h0, 1'b0);
        add_cmd(CMD_SORT, 16'h0, 32'h0, 1'b0);
        // fill to the top with duplicate ids, tied and extreme run times
        for (int i = 0; i < QUEUE_DEPTH; i++)
            add_cmd(CMD_ENQ, i == 0 ? 16'h0 : i == QUEUE_DEPTH - 1 ? 16'hFFFF : 16'(i % 5),
                    i == 1 ? 32'hFFFF_FFFF : i == 2 ? 32'h0 : 32'((i % 3) * 7), 1'b0);
        add_cmd(CMD_ENQ, 16'hBEEF, 32'h1234_5678, 1'b0);
        add_cmd(CMD_SORT, 16'h0, 32'h0, 1'b0);
        add_cmd(CMD_REMOVE, 16'h1234, 32'h0, 1'b0);
        add_cmd(CMD_REMOVE, 16'h2, 32'h0, 1'b0);
        add_cmd(CMD_DEQ, 16'h0, 32'h0, 1'b0);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            mix     = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 40);
            // the first segment always waits for the block to empty out
            drain   = (made == 0) || ($urandom_range(0, 3) == 0);
            for (int j = 0; j < seg_len && made < RANDOM_ITEMS; j++)
            begin
                add_cmd(pick_command(mix), pick_id(), pick_runtime(), drain && j == 0);
                made++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("tb: %0d results checked, %0d sorts, %0d mismatches", result_count,
                 sort_count, mismatch_count);
        $display("tb: status counts ok %0d, empty %0d, full %0d, not found %0d",
                 status_seen[STAT_OK], status_seen[STAT_EMPTY], status_seen[STAT_FULL],
                 status_seen[STAT_NOTFOUND]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sjf_job_queue_unit.f
design/sjfq_pkg.sv
design/sjfq_cell.sv
design/sjf_job_queue_unit.sv
bench/tb.sv
